### src/blfe_pkg.sv
// Shared types, constants and register codes of the byte-limited FIFO with ECN marking.
`default_nettype none
package blfe_pkg;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned SIZE_W   = 14;
  localparam int unsigned BYTES_W  = 20;
  localparam int unsigned TPB_W    = 8;
  localparam int unsigned TIMER_W  = 24;
  localparam int unsigned PROD_W   = SIZE_W + TPB_W;
  localparam int unsigned CFG_W    = 20;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 64;

  localparam int unsigned FQ_PTR_W = 1;
  localparam int unsigned FQ_CNT_W = 2;
  localparam logic [FQ_CNT_W-1:0] FQ_DEPTH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECN_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ECN_ENABLE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BYTE = 2'd3;

  localparam logic [BYTES_W-1:0] RST_MAX_BYTES      = 20'd1048575;
  localparam logic [BYTES_W-1:0] RST_ECN_THRESHOLD  = 20'd65536;
  localparam logic [TPB_W-1:0]   RST_TICKS_PER_BYTE = 8'd1;

  typedef enum logic {
    CMD_ARRIVAL = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    EV_ACCEPTED = 2'd0,
    EV_DROPPED  = 2'd1,
    EV_DEPARTED = 2'd2
  } kind_e;

  typedef enum logic {
    ST_RUN  = 1'b0,
    ST_LOAD = 1'b1
  } back_state_e;

  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]   pkt_id;
    logic [SIZE_W-1:0] pkt_size;
  } in_item_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } front_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } desc_t;

  typedef struct packed {
    kind_e              event_kind;
    logic [ID_W-1:0]    out_id;
    logic [SIZE_W-1:0]  out_size;
    logic               ecn_mark;
    logic [BYTES_W-1:0] queued_bytes;
  } res_item_t;

  typedef struct packed {
    logic [BYTES_W-1:0] max_bytes;
    logic [BYTES_W-1:0] ecn_threshold;
    logic               ecn_enable;
    logic [TPB_W-1:0]   ticks_per_byte;
  } cfg_t;

endpackage
`default_nettype wire

### src/byte_limited_fifo_with_ecn.sv
// Top level of the byte-limited packet FIFO with tail drop and ECN marking.
//
// Input items enter through push/full: an item is taken when push is high and full is
// low. An arrival (cmd 0) always yields one result, accepted or dropped; a tick (cmd 1)
// yields a departed result only on the tick that ends the head packet's service.
// Results leave through empty/pop; the oldest result sits on res_item_o while empty
// is low and is taken when pop is high.
// Items are registered in a two-entry input queue that feeds the engine; their results
// are registered in a two-entry result queue that drains it.
// Throughput: one item per cycle while the result queue has room, except that no item
// is taken in ST_LOAD after a departure leaving packets queued, as the next head
// descriptor is read from a registered memory port and its service time computed.
// When the result side stalls, the result queue fills, the engine halts and the input
// queue fills in turn, after which full goes high; nothing is lost. Reset empties
// both queues and the packet store, clears the byte count and loads the configuration
// registers with their defaults; no clearing pass is needed. Configuration writes take
// effect at the next edge; the user makes them only while idle, which is not enforced.
`default_nettype none
module byte_limited_fifo_with_ecn
  import blfe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire in_item_t              in_item_i,
  output logic                       empty,
  input  wire logic                  pop,
  output res_item_t                  res_item_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  cfg_t         cfg_q;
  logic         front_valid, front_pop;
  front_item_t  front_item;
  logic         res_full, res_push;
  res_item_t    res_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_bytes      <= RST_MAX_BYTES;
      cfg_q.ecn_threshold  <= RST_ECN_THRESHOLD;
      cfg_q.ecn_enable     <= 1'b0;
      cfg_q.ticks_per_byte <= RST_TICKS_PER_BYTE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_BYTES:      cfg_q.max_bytes      <= cfg_data_i[BYTES_W-1:0];
        CFG_ECN_THRESHOLD:  cfg_q.ecn_threshold  <= cfg_data_i[BYTES_W-1:0];
        CFG_ECN_ENABLE:     cfg_q.ecn_enable     <= cfg_data_i[0];
        CFG_TICKS_PER_BYTE: cfg_q.ticks_per_byte <= cfg_data_i[TPB_W-1:0];
        default: ;
      endcase
    end
  end

  blfe_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item_i),
    .full_o  (full),
    .valid_o (front_valid),
    .item_o  (front_item),
    .pop_i   (front_pop)
  );

  blfe_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (front_valid),
    .item_i       (front_item),
    .item_pop_o   (front_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_item_o   (res_item)
  );

  blfe_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res_item),
    .full_o  (res_full),
    .empty_o (empty),
    .item_o  (res_item_o),
    .pop_i   (pop)
  );

endmodule
`default_nettype wire

### src/blfe_front.sv
// Front end: two-entry input queue that takes items and decodes their command.
`default_nettype none
module blfe_front
  import blfe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire in_item_t    item_i,
  output logic             full_o,
  output logic             valid_o,
  output front_item_t      item_o,
  input  wire logic        pop_i
);

  in_item_t             slot_q [2];
  logic [FQ_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FQ_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic                 do_push, do_pop;
  in_item_t             head;

  assign full_o  = (cnt_q == FQ_DEPTH);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign head    = slot_q[rd_ptr_q];

  always_comb begin
    item_o.cmd  = cmd_e'(head.cmd);
    item_o.id   = head.pkt_id;
    item_o.size = head.pkt_size;
  end

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + FQ_CNT_W'(do_push) - FQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

### src/blfe_res_fifo.sv
// Two-entry result queue between the back end and the result ports.
`default_nettype none
module blfe_res_fifo
  import blfe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire res_item_t  item_i,
  output logic            full_o,
  output logic            empty_o,
  output res_item_t       item_o,
  input  wire logic       pop_i
);

  res_item_t            slot_q [2];
  logic [FQ_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FQ_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == FQ_DEPTH);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + FQ_CNT_W'(do_push) - FQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

### src/blfe_back.sv
// Back end: descriptor store, byte accounting, service timer and departure marking.
`default_nettype none
module blfe_back
  import blfe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cfg_t         cfg_i,
  input  wire logic         item_valid_i,
  input  wire front_item_t  item_i,
  output logic              item_pop_o,
  input  wire logic         res_full_i,
  output logic              res_push_o,
  output res_item_t         res_item_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  desc_t               mem_q [QUEUE_DEPTH];
  desc_t               rd_data_q;
  back_state_e         state_q, state_d;
  logic [PTR_W-1:0]    head_ptr_q, head_ptr_d;
  logic [PTR_W-1:0]    tail_ptr_q, tail_ptr_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [BYTES_W-1:0]  bytes_q, bytes_d;
  logic [TIMER_W-1:0]  timer_q, timer_d;
  logic [ID_W-1:0]     head_id_q, head_id_d;
  logic [SIZE_W-1:0]   head_size_q, head_size_d;

  logic                take, is_arrival, fits, due, depart, mem_we, load;
  logic [BYTES_W:0]    sum;
  logic [BYTES_W-1:0]  bytes_left;
  logic [PROD_W-1:0]   prod_arr, prod_load;

  assign take       = (state_q == ST_RUN) && item_valid_i && !res_full_i;
  assign is_arrival = (item_i.cmd == CMD_ARRIVAL);
  assign sum        = {1'b0, bytes_q} + (BYTES_W + 1)'(item_i.size);
  assign fits       = (sum <= {1'b0, cfg_i.max_bytes}) && (count_q != FULL_CNT);
  assign due        = (count_q != '0) && (timer_q < TIMER_W'(2));
  assign depart     = take && !is_arrival && due;
  assign mem_we     = take && is_arrival && fits;
  assign load       = (state_q == ST_LOAD);
  assign bytes_left = (bytes_q >= BYTES_W'(head_size_q)) ?
                      bytes_q - BYTES_W'(head_size_q) : '0;
  assign prod_arr   = PROD_W'(item_i.size) * PROD_W'(cfg_i.ticks_per_byte);
  assign prod_load  = PROD_W'(rd_data_q.size) * PROD_W'(cfg_i.ticks_per_byte);
  assign item_pop_o = take;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN:  if (depart && (count_q != CNT_W'(1))) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_RUN;
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    head_ptr_d  = head_ptr_q;
    tail_ptr_d  = tail_ptr_q;
    count_d     = count_q;
    bytes_d     = bytes_q;
    timer_d     = timer_q;
    head_id_d   = head_id_q;
    head_size_d = head_size_q;
    res_push_o  = 1'b0;
    res_item_o.event_kind   = EV_DROPPED;
    res_item_o.out_id       = item_i.id;
    res_item_o.out_size     = item_i.size;
    res_item_o.ecn_mark     = 1'b0;
    res_item_o.queued_bytes = bytes_q;
    if (load) begin
      head_id_d   = rd_data_q.id;
      head_size_d = rd_data_q.size;
      timer_d     = TIMER_W'(prod_load);
    end else if (take && is_arrival) begin
      res_push_o = 1'b1;
      if (fits) begin
        tail_ptr_d = next_slot(tail_ptr_q);
        count_d    = count_q + 1'b1;
        bytes_d    = sum[BYTES_W-1:0];
        res_item_o.event_kind   = EV_ACCEPTED;
        res_item_o.queued_bytes = sum[BYTES_W-1:0];
        if (count_q == '0) begin
          head_id_d   = item_i.id;
          head_size_d = item_i.size;
          timer_d     = TIMER_W'(prod_arr);
        end
      end
    end else if (depart) begin
      res_push_o = 1'b1;
      head_ptr_d = next_slot(head_ptr_q);
      count_d    = count_q - 1'b1;
      bytes_d    = bytes_left;
      timer_d    = '0;
      res_item_o.event_kind   = EV_DEPARTED;
      res_item_o.out_id       = head_id_q;
      res_item_o.out_size     = head_size_q;
      res_item_o.ecn_mark     = cfg_i.ecn_enable && (bytes_left > cfg_i.ecn_threshold);
      res_item_o.queued_bytes = bytes_left;
    end else if (take && (count_q != '0)) begin
      timer_d = timer_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      head_ptr_q <= '0;
      tail_ptr_q <= '0;
      count_q    <= '0;
      bytes_q    <= '0;
      timer_q    <= '0;
    end else begin
      state_q    <= state_d;
      head_ptr_q <= head_ptr_d;
      tail_ptr_q <= tail_ptr_d;
      count_q    <= count_d;
      bytes_q    <= bytes_d;
      timer_q    <= timer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_id_q   <= head_id_d;
    head_size_q <= head_size_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_ptr_q] <= '{id: item_i.id, size: item_i.size};
    end
    rd_data_q <= mem_q[next_slot(head_ptr_q)];
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT) else $error("descriptor count beyond depth");

  a_empty_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (bytes_q == '0)) else $error("bytes held with empty queue");

  a_load_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |=> (state_q == ST_RUN)) else $error("head load stuck");

  a_load_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (count_q != '0)) else $error("head load on empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i) else $error("result pushed into full queue");

endmodule
`default_nettype wire
